/* design/position_sum_hysteresis_classifier_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the position sum hysteresis classifier
// Shared concurrent assertion forms, clocked on clk and quiet during rst.
// ---------------------------------------------------------------------------
`ifndef POSITION_SUM_HYSTERESIS_CLASSIFIER_DEFINES_SVH
`define POSITION_SUM_HYSTERESIS_CLASSIFIER_DEFINES_SVH

// property holds in the same cycle as its trigger
`define PSH_ASSERT_SAME(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
    else $error(msg);

// property holds in the cycle after its trigger
`define PSH_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
    else $error(msg);

`endif

/* design/psh_pkg.sv */
// ---------------------------------------------------------------------------
// Position sum hysteresis classifier package
// Field widths, request and state codes, register map and reset values.
// ---------------------------------------------------------------------------
package psh_pkg;

  // field widths
  localparam int REQ_W    = 2;
  localparam int SAMPLE_W = 10;
  localparam int SUM_W    = 14;
  localparam int HYST_W   = 12;
  localparam int COUNT_W  = 8;
  localparam int STATE_W  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // ring depth default
  localparam int RING_DEPTH_DEF = 4;

  // request codes
  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CHECK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  // position codes
  localparam logic [STATE_W-1:0] ST_CLOSED = 2'd0;
  localparam logic [STATE_W-1:0] ST_MOVING = 2'd1;
  localparam logic [STATE_W-1:0] ST_OPEN   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_THR       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_THR        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST_WIDTH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_CLOSE_THR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_OPEN_THR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_DELTA      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_LIMIT     = 3'd6;

  // register reset values
  localparam logic [SUM_W-1:0]   CLOSE_THR_RST       = 14'd1628;
  localparam logic [SUM_W-1:0]   OPEN_THR_RST        = 14'd2040;
  localparam logic [HYST_W-1:0]  HYST_WIDTH_RST      = 12'd34;
  localparam logic [SUM_W-1:0]   MOTOR_CLOSE_THR_RST = 14'd1218;
  localparam logic [SUM_W-1:0]   MOTOR_OPEN_THR_RST  = 14'd2416;
  localparam logic [SUM_W-1:0]   MOVE_DELTA_RST      = 14'd2;
  localparam logic [COUNT_W-1:0] STALL_LIMIT_RST     = 8'd10;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hff;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [SUM_W-1:0]   close_thr;
    logic [SUM_W-1:0]   open_thr;
    logic [HYST_W-1:0]  hyst_width;
    logic [SUM_W-1:0]   motor_close_thr;
    logic [SUM_W-1:0]   motor_open_thr;
    logic [SUM_W-1:0]   move_delta;
    logic [COUNT_W-1:0] stall_limit;
  } cfg_t;

  // per-beat classification result
  typedef struct packed {
    logic [STATE_W-1:0] position_state;
    logic [STATE_W-1:0] motor_state;
    logic               motor_moving;
  } class_t;

endpackage

/* design/psh_cfg_if.sv */
// ---------------------------------------------------------------------------
// Configuration write channel
// Register index and write data with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface psh_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [psh_pkg::CFG_IDX_W-1:0]    index;
  logic [psh_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/psh_req_if.sv */
// ---------------------------------------------------------------------------
// Request channel
// One request beat: request type and raw sensor sample.
// ---------------------------------------------------------------------------
interface psh_req_if;
  logic                          valid;
  logic                          ready;
  logic [psh_pkg::REQ_W-1:0]     req_type;
  logic [psh_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, req_type, sample, input ready);
  modport sink   (input valid, req_type, sample, output ready);
endinterface

/* design/psh_res_if.sv */
// ---------------------------------------------------------------------------
// Result channel
// One result beat: position and motor states, ring sum, moving flag.
// ---------------------------------------------------------------------------
interface psh_res_if;
  logic                          valid;
  logic                          ready;
  logic [psh_pkg::STATE_W-1:0]   position_state;
  logic [psh_pkg::STATE_W-1:0]   motor_state;
  logic [psh_pkg::SUM_W-1:0]     position_sum;
  logic                          motor_moving;

  modport source (output valid, position_state, motor_state, position_sum, motor_moving,
                  input ready);
  modport sink   (input valid, position_state, motor_state, position_sum, motor_moving,
                  output ready);
endinterface

/* design/psh_cfg_regs.sv */
// ---------------------------------------------------------------------------
// Configuration register file
// Seven threshold registers, written one beat at a time, always ready.
// ---------------------------------------------------------------------------
module psh_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  psh_cfg_if.sink        cfg,
  output psh_pkg::cfg_t  regs
);

  assign cfg.ready = 1'b1;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.close_thr       <= psh_pkg::CLOSE_THR_RST;
      regs.open_thr        <= psh_pkg::OPEN_THR_RST;
      regs.hyst_width      <= psh_pkg::HYST_WIDTH_RST;
      regs.motor_close_thr <= psh_pkg::MOTOR_CLOSE_THR_RST;
      regs.motor_open_thr  <= psh_pkg::MOTOR_OPEN_THR_RST;
      regs.move_delta      <= psh_pkg::MOVE_DELTA_RST;
      regs.stall_limit     <= psh_pkg::STALL_LIMIT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        psh_pkg::CFG_CLOSE_THR:       regs.close_thr       <= cfg.data;
        psh_pkg::CFG_OPEN_THR:        regs.open_thr        <= cfg.data;
        psh_pkg::CFG_HYST_WIDTH:      regs.hyst_width      <= cfg.data[psh_pkg::HYST_W-1:0];
        psh_pkg::CFG_MOTOR_CLOSE_THR: regs.motor_close_thr <= cfg.data;
        psh_pkg::CFG_MOTOR_OPEN_THR:  regs.motor_open_thr  <= cfg.data;
        psh_pkg::CFG_MOVE_DELTA:      regs.move_delta      <= cfg.data;
        psh_pkg::CFG_STALL_LIMIT:     regs.stall_limit     <= cfg.data[psh_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* design/psh_ring.sv */
// ---------------------------------------------------------------------------
// Sample ring and running sum
// Holds the last RING_DEPTH samples and keeps their sum up to date.
// ---------------------------------------------------------------------------
`include "position_sum_hysteresis_classifier_defines.svh"

module psh_ring #(
  parameter int RING_DEPTH = psh_pkg::RING_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic [psh_pkg::SAMPLE_W-1:0] sample,
  output logic [psh_pkg::SUM_W-1:0]    sum_post
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);
  localparam logic [psh_pkg::SUM_W-1:0] SUM_MAX =
    psh_pkg::SUM_W'(RING_DEPTH * ((1 << psh_pkg::SAMPLE_W) - 1));

  logic [psh_pkg::SAMPLE_W-1:0] ring [RING_DEPTH];
  logic [IDX_W-1:0]             wr_idx;
  logic [psh_pkg::SUM_W-1:0]    sum;
  logic [psh_pkg::SUM_W-1:0]    sum_next;

  // swap the oldest entry for the new sample; the sum never exceeds SUM_MAX
  always_comb begin
    sum_next = sum + psh_pkg::SUM_W'(sample) - psh_pkg::SUM_W'(ring[wr_idx]);
    sum_post = load ? sum_next : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring[i] <= '0;
      end
      wr_idx <= '0;
      sum    <= '0;
    end else if (load) begin
      ring[wr_idx] <= sample;
      wr_idx       <= (wr_idx == IDX_LAST) ? '0 : wr_idx + 1'b1;
      sum          <= sum_next;
    end
  end

  `PSH_ASSERT_NEXT(a_idx_step, load && wr_idx != IDX_LAST, wr_idx == $past(wr_idx) + 1'b1, "ring index did not step")
  `PSH_ASSERT_SAME(a_sum_bound, 1'b1, sum <= SUM_MAX, "ring sum beyond full scale")

endmodule

/* design/psh_track.sv */
// ---------------------------------------------------------------------------
// Position classifier and stall tracker
// Hysteresis and motor classification of the sum, movement check counter.
// ---------------------------------------------------------------------------
`include "position_sum_hysteresis_classifier_defines.svh"

module psh_track (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [psh_pkg::REQ_W-1:0]  req_type,
  input  logic [psh_pkg::SUM_W-1:0]  sum_post,
  input  psh_pkg::cfg_t              regs,
  output psh_pkg::class_t            result
);

  logic                          classified_once;
  logic [psh_pkg::STATE_W-1:0]   held_state;
  logic [psh_pkg::STATE_W-1:0]   motor_held_state;
  logic [psh_pkg::COUNT_W-1:0]   stall_count;
  logic [psh_pkg::SUM_W-1:0]     last_check_sum;

  logic                          classified_once_next;
  logic [psh_pkg::STATE_W-1:0]   held_state_next;
  logic [psh_pkg::STATE_W-1:0]   motor_held_state_next;
  logic [psh_pkg::COUNT_W-1:0]   stall_count_next;
  logic [psh_pkg::SUM_W-1:0]     last_check_sum_next;

  logic [psh_pkg::SUM_W:0]       close_band;
  logic [psh_pkg::SUM_W:0]       sum_plus_hyst;
  logic [psh_pkg::SUM_W-1:0]     diff;

  function automatic logic [psh_pkg::STATE_W-1:0] plain_class(
    input logic [psh_pkg::SUM_W-1:0] s,
    input logic [psh_pkg::SUM_W-1:0] lo,
    input logic [psh_pkg::SUM_W-1:0] hi
  );
    logic [psh_pkg::STATE_W-1:0] st;
    if (s < lo) begin
      st = psh_pkg::ST_CLOSED;
    end else if (s < hi) begin
      st = psh_pkg::ST_MOVING;
    end else begin
      st = psh_pkg::ST_OPEN;
    end
    return st;
  endfunction

  // band edges at one bit wider; s < open - h is tested as s + h < open
  assign close_band    = {1'b0, regs.close_thr} + (psh_pkg::SUM_W + 1)'(regs.hyst_width);
  assign sum_plus_hyst = {1'b0, sum_post} + (psh_pkg::SUM_W + 1)'(regs.hyst_width);
  assign diff = (sum_post > last_check_sum) ? sum_post - last_check_sum
                                            : last_check_sum - sum_post;

  // next state for the beat in flight
  always_comb begin
    classified_once_next  = classified_once;
    held_state_next       = held_state;
    motor_held_state_next = motor_held_state;
    stall_count_next      = stall_count;
    last_check_sum_next   = last_check_sum;
    case (req_type)
      psh_pkg::REQ_SAMPLE: begin
        motor_held_state_next = plain_class(sum_post, regs.motor_close_thr,
                                            regs.motor_open_thr);
        classified_once_next  = 1'b1;
        if (!classified_once) begin
          held_state_next = plain_class(sum_post, regs.close_thr, regs.open_thr);
        end else if (sum_post < regs.close_thr) begin
          held_state_next = psh_pkg::ST_CLOSED;
        end else if ({1'b0, sum_post} < close_band) begin
          held_state_next = held_state;
        end else if (sum_plus_hyst < {1'b0, regs.open_thr}) begin
          held_state_next = psh_pkg::ST_MOVING;
        end else if (sum_post < regs.open_thr) begin
          held_state_next = held_state;
        end else begin
          held_state_next = psh_pkg::ST_OPEN;
        end
      end
      psh_pkg::REQ_CHECK: begin
        last_check_sum_next = sum_post;
        if (diff > regs.move_delta) begin
          if (stall_count > 8'd1) begin
            stall_count_next = stall_count - 8'd2;
          end
        end else if (stall_count != psh_pkg::COUNT_MAX) begin
          stall_count_next = stall_count + 8'd1;
        end
      end
      psh_pkg::REQ_CLEAR: begin
        stall_count_next = '0;
      end
      default: ;
    endcase
  end

  assign result.position_state = held_state_next;
  assign result.motor_state    = motor_held_state_next;
  assign result.motor_moving   = stall_count_next < regs.stall_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      classified_once  <= 1'b0;
      held_state       <= psh_pkg::ST_OPEN;
      motor_held_state <= psh_pkg::ST_OPEN;
      stall_count      <= '0;
      last_check_sum   <= '0;
    end else if (step) begin
      classified_once  <= classified_once_next;
      held_state       <= held_state_next;
      motor_held_state <= motor_held_state_next;
      stall_count      <= stall_count_next;
      last_check_sum   <= last_check_sum_next;
    end
  end

  `PSH_ASSERT_SAME(a_open_until_first, !classified_once, held_state == psh_pkg::ST_OPEN, "state left open before first sample")
  `PSH_ASSERT_NEXT(a_clear_count, step && req_type == psh_pkg::REQ_CLEAR, stall_count == '0, "stall counter not cleared")

endmodule

/* design/position_sum_hysteresis_classifier.sv */
// ---------------------------------------------------------------------------
// Position sum hysteresis classifier
// Ring sum of position samples, hysteresis and motor classification, stall check.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one request a beat: a sensor sample, a movement check or a
//   stall counter clear. res returns exactly one beat per request, in order,
//   with the position state, motor state, ring sum and motor moving flag.
//   cfg writes the threshold registers by index; it is always ready and
//   should only be used while no request is in flight.
// Timing:
//   A request is held in the input register and is classified on its way
//   into the result register, whose output drives res.valid. The block
//   takes one request per cycle while res keeps accepting results; the sum,
//   classifier and stall counter update as a beat moves between the two
//   registers.
// Stalls and reset:
//   While res is held off, the result stays put and one more request is
//   taken into the input register; req.ready then drops until res moves.
//   Reset clears the ring, sum, counter and states (position reads open) and
//   restores the register defaults. There is no clearing pass.
// ---------------------------------------------------------------------------
`include "position_sum_hysteresis_classifier_defines.svh"

module position_sum_hysteresis_classifier #(
  parameter int RING_DEPTH = psh_pkg::RING_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  psh_cfg_if.sink   cfg,
  psh_req_if.sink   req,
  psh_res_if.source res
);

  psh_pkg::cfg_t   regs;
  psh_pkg::class_t result;

  logic                         in_valid;
  logic [psh_pkg::REQ_W-1:0]    in_req_type;
  logic [psh_pkg::SAMPLE_W-1:0] in_sample;
  logic                         advance;
  logic [psh_pkg::SUM_W-1:0]    sum_post;

  logic                         out_valid;
  logic [psh_pkg::STATE_W-1:0]  out_position_state;
  logic [psh_pkg::STATE_W-1:0]  out_motor_state;
  logic [psh_pkg::SUM_W-1:0]    out_position_sum;
  logic                         out_motor_moving;

  psh_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // beat moves from input register to result register
  assign advance   = in_valid && (!out_valid || res.ready);
  assign req.ready = !in_valid || advance;

  psh_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && in_req_type == psh_pkg::REQ_SAMPLE),
    .sample   (in_sample),
    .sum_post (sum_post)
  );

  psh_track u_track (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .req_type (in_req_type),
    .sum_post (sum_post),
    .regs     (regs),
    .result   (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_req_type <= req.req_type;
      in_sample   <= req.sample;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_position_state <= result.position_state;
      out_motor_state    <= result.motor_state;
      out_position_sum   <= sum_post;
      out_motor_moving   <= result.motor_moving;
    end
  end

  assign res.valid          = out_valid;
  assign res.position_state = out_position_state;
  assign res.motor_state    = out_motor_state;
  assign res.position_sum   = out_position_sum;
  assign res.motor_moving   = out_motor_moving;

  `PSH_ASSERT_SAME(a_backpressure, !req.ready, in_valid && out_valid && !res.ready, "input held off without a full stall")
  `PSH_ASSERT_NEXT(a_result_lands, advance, out_valid, "advanced beat missing from result register")

endmodule

/* sim/psh_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Result checker for the position sum hysteresis classifier
// Watches the configuration, request and result channels, keeps its own copy
// of the registers, ring, classifiers and stall counter, predicts one result
// beat per accepted request and compares each result beat field by field.
// ----------------------------------------------------------------------------
module psh_result_checker (
  input  logic clk,
  input  logic rst,
  psh_cfg_if   cfg,
  psh_req_if   req,
  psh_res_if   res,
  output int   errors,
  output int   pending
);
  import psh_pkg::*;

  typedef struct packed {
    logic [STATE_W-1:0] position_state;
    logic [STATE_W-1:0] motor_state;
    logic [SUM_W-1:0]   position_sum;
    logic               motor_moving;
  } psh_beat_t;

  // register copy
  logic [SUM_W-1:0]    close_thr;
  logic [SUM_W-1:0]    open_thr;
  logic [HYST_W-1:0]   hyst_width;
  logic [SUM_W-1:0]    motor_close_thr;
  logic [SUM_W-1:0]    motor_open_thr;
  logic [SUM_W-1:0]    move_delta;
  logic [COUNT_W-1:0]  stall_limit;

  // datapath copy
  logic [SAMPLE_W-1:0] ring [RING_DEPTH_DEF];
  int                  wr_idx;
  logic [SUM_W-1:0]    ring_sum;
  logic [SUM_W-1:0]    last_check_sum;
  logic                classified;
  logic [STATE_W-1:0]  held_state;
  logic [STATE_W-1:0]  motor_held;
  logic [COUNT_W-1:0]  stall_count;

  psh_beat_t           expected_beats [$];
  int                  fail_count = 0;
  int                  outstanding = 0;

  assign errors  = fail_count;
  assign pending = outstanding;

  // plain three-way split, no hysteresis
  function automatic logic [STATE_W-1:0] split_three(int s, int lo, int hi);
    if (s < lo) return ST_CLOSED;
    if (s < hi) return ST_MOVING;
    return ST_OPEN;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic clear_model();
    close_thr       = CLOSE_THR_RST;
    open_thr        = OPEN_THR_RST;
    hyst_width      = HYST_WIDTH_RST;
    motor_close_thr = MOTOR_CLOSE_THR_RST;
    motor_open_thr  = MOTOR_OPEN_THR_RST;
    move_delta      = MOVE_DELTA_RST;
    stall_limit     = STALL_LIMIT_RST;
    for (int i = 0; i < RING_DEPTH_DEF; i++) ring[i] = '0;
    wr_idx         = 0;
    ring_sum       = '0;
    last_check_sum = '0;
    classified     = 1'b0;
    held_state     = ST_OPEN;
    motor_held     = ST_OPEN;
    stall_count    = '0;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_CLOSE_THR:       close_thr       = val;
      CFG_OPEN_THR:        open_thr        = val;
      CFG_HYST_WIDTH:      hyst_width      = val[HYST_W-1:0];
      CFG_MOTOR_CLOSE_THR: motor_close_thr = val;
      CFG_MOTOR_OPEN_THR:  motor_open_thr  = val;
      CFG_MOVE_DELTA:      move_delta      = val;
      CFG_STALL_LIMIT:     stall_limit     = val[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  // apply one request and work out the result beat it produces
  task automatic predict_beat(input logic [REQ_W-1:0] kind,
                              input logic [SAMPLE_W-1:0] smp,
                              output psh_beat_t beat);
    int               acc;
    int               s;
    int               c;
    int               o;
    int               h;
    logic [SUM_W-1:0] diff;
    case (kind)
      REQ_SAMPLE: begin
        ring[wr_idx] = smp;
        wr_idx = (wr_idx == RING_DEPTH_DEF - 1) ? 0 : wr_idx + 1;
        acc = 0;
        for (int i = 0; i < RING_DEPTH_DEF; i++) acc += ring[i];
        ring_sum = acc[SUM_W-1:0];
        s = ring_sum;
        c = close_thr;
        o = open_thr;
        h = hyst_width;
        motor_held = split_three(s, motor_close_thr, motor_open_thr);
        if (!classified) begin
          held_state = split_three(s, c, o);
          classified = 1'b1;
        end else if (s < c) begin
          held_state = ST_CLOSED;
        end else if (s >= c + h) begin
          // below o - h moves, between o - h and o holds
          if (s < o - h) held_state = ST_MOVING;
          else if (s >= o) held_state = ST_OPEN;
        end
      end
      REQ_CHECK: begin
        diff = (ring_sum > last_check_sum) ? ring_sum - last_check_sum
                                           : last_check_sum - ring_sum;
        last_check_sum = ring_sum;
        if (diff > move_delta) begin
          if (stall_count > 1) stall_count = stall_count - COUNT_W'(2);
        end else if (stall_count != COUNT_MAX) begin
          stall_count++;
        end
      end
      REQ_CLEAR: stall_count = '0;
      default: ;
    endcase
    beat.position_state = held_state;
    beat.motor_state    = motor_held;
    beat.position_sum   = ring_sum;
    beat.motor_moving   = (stall_count < stall_limit);
  endtask

  // per-edge monitor: register writes, result compare, then new requests
  always @(posedge clk) begin
    psh_beat_t beat;
    psh_beat_t want;
    if (rst) begin
      clear_model();
      expected_beats.delete();
    end else begin
      if (cfg.valid && cfg.ready) write_register(cfg.index, cfg.data);
      if (res.valid && res.ready) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with no request outstanding");
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          check_field("position_state", want.position_state, res.position_state);
          check_field("motor_state", want.motor_state, res.motor_state);
          check_field("position_sum", want.position_sum, res.position_sum);
          check_field("motor_moving", want.motor_moving, res.motor_moving);
        end
      end
      if (req.valid && req.ready) begin
        predict_beat(req.req_type, req.sample, beat);
        expected_beats.push_back(beat);
      end
    end
    outstanding <= expected_beats.size();
  end

endmodule

/* sim/tb_position_sum_hysteresis_classifier.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the position sum hysteresis classifier
// Drives directed and random request beats through several register settings,
// with random gaps on the request side and random hold-off on the result side.
// The checker alongside predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_position_sum_hysteresis_classifier;
  import psh_pkg::*;

  localparam logic [REQ_W-1:0]     REQ_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE   = 3'd7;

  logic clk;
  logic rst;
  logic idle_on = 1'b1;
  int   errors;
  int   pending;

  // register values as last written, used to steer samples near thresholds
  logic [CFG_DATA_W-1:0] reg_shadow [7];
  int                    aim;

  psh_cfg_if cfg_bus ();
  psh_req_if req_bus ();
  psh_res_if res_bus ();

  position_sum_hysteresis_classifier uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_bus),
    .req (req_bus),
    .res (res_bus)
  );

  psh_result_checker checker_i (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .req     (req_bus),
    .res     (res_bus),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb_position_sum_hysteresis_classifier: errors");
    $finish;
  end

  // result side: random hold-off bursts while idling is enabled
  initial begin
    res_bus.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
        res_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      res_bus.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // one request beat; valid stays high on return
  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [SAMPLE_W-1:0] smp);
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.sample   <= smp;
    do @(posedge clk); while (!req_bus.ready);
  endtask

  task automatic idle_req(input int n);
    req_bus.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // stop sending until every outstanding result beat has come back
  task automatic drain();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // one config beat; valid stays high on return
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx != CFG_NONE) reg_shadow[idx] = val;
  endtask

  // full register set, plus a write to the unmapped index; block must be idle
  task automatic set_config(input logic [CFG_DATA_W-1:0] c_thr, o_thr, hyst,
                            input logic [CFG_DATA_W-1:0] mc_thr, mo_thr, delta, limit);
    cfg_write(CFG_CLOSE_THR, c_thr);
    cfg_write(CFG_OPEN_THR, o_thr);
    cfg_write(CFG_HYST_WIDTH, hyst);
    cfg_write(CFG_MOTOR_CLOSE_THR, mc_thr);
    cfg_write(CFG_MOTOR_OPEN_THR, mo_thr);
    cfg_write(CFG_MOVE_DELTA, delta);
    cfg_write(CFG_STALL_LIMIT, limit);
    cfg_write(CFG_NONE, CFG_DATA_W'($urandom));
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // random request mix; samples often sit near one of the thresholds
  task automatic send_random(input int n);
    int               pick;
    int               target;
    int               hyst;
    logic [REQ_W-1:0] kind;
    logic [SAMPLE_W-1:0] smp;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) kind = REQ_SAMPLE;
      else if (pick < 85) kind = REQ_CHECK;
      else if (pick < 93) kind = REQ_CLEAR;
      else kind = REQ_UNUSED;
      smp = SAMPLE_W'($urandom);
      if ($urandom_range(0, 15) == 0) aim = $urandom_range(0, 5);
      if (kind == REQ_SAMPLE) begin
        hyst = int'(reg_shadow[CFG_HYST_WIDTH] & 14'hfff);
        case (aim)
          0: target = int'(reg_shadow[CFG_CLOSE_THR]);
          1: target = int'(reg_shadow[CFG_CLOSE_THR]) + hyst;
          2: target = int'(reg_shadow[CFG_OPEN_THR]) - hyst;
          3: target = int'(reg_shadow[CFG_OPEN_THR]);
          4: target = int'(reg_shadow[CFG_MOTOR_CLOSE_THR]);
          default: target = int'(reg_shadow[CFG_MOTOR_OPEN_THR]);
        endcase
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          target = target / 4 + $urandom_range(0, 12) - 6;
          if (target < 0) target = 0;
          if (target > 1023) target = 1023;
          smp = SAMPLE_W'(target);
        end else if (pick == 8) begin
          smp = '0;
        end else if (pick == 9) begin
          smp = '1;
        end
      end
      send_req(kind, smp);
      if (idle_on && $urandom_range(0, 5) == 0) idle_req($urandom_range(1, 7));
    end
  endtask

  // stimulus and verdict
  initial begin
    rst              <= 1'b1;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.index    <= '0;
    cfg_bus.data     <= '0;
    req_bus.valid    <= 1'b0;
    req_bus.req_type <= '0;
    req_bus.sample   <= '0;
    reg_shadow[CFG_CLOSE_THR]       = CLOSE_THR_RST;
    reg_shadow[CFG_OPEN_THR]        = OPEN_THR_RST;
    reg_shadow[CFG_HYST_WIDTH]      = CFG_DATA_W'(HYST_WIDTH_RST);
    reg_shadow[CFG_MOTOR_CLOSE_THR] = MOTOR_CLOSE_THR_RST;
    reg_shadow[CFG_MOTOR_OPEN_THR]  = MOTOR_OPEN_THR_RST;
    reg_shadow[CFG_MOVE_DELTA]      = MOVE_DELTA_RST;
    reg_shadow[CFG_STALL_LIMIT]     = CFG_DATA_W'(STALL_LIMIT_RST);
    aim = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: unused request before any sample, first plain classification,
    // full-scale ring, stall counter past its limit, movement, clear
    send_req(REQ_UNUSED, 10'h3ff);
    send_req(REQ_CHECK, 10'h000);
    repeat (4) send_req(REQ_SAMPLE, 10'h3ff);
    send_req(REQ_SAMPLE, 10'h000);
    send_req(REQ_CHECK, 10'h3ff);
    repeat (12) send_req(REQ_CHECK, 10'h155);
    send_req(REQ_SAMPLE, 10'h000);
    send_req(REQ_CHECK, 10'h2aa);
    send_req(REQ_CLEAR, 10'h3ff);
    send_req(REQ_SAMPLE, 10'h155);
    send_req(REQ_SAMPLE, 10'h2aa);

    // reset register values, with a full drain part-way through
    send_random(75);
    drain();
    send_random(75);
    drain();

    // all registers at zero
    set_config('0, '0, '0, '0, '0, '0, '0);
    send_random(80);
    drain();

    // all registers at full scale, masked fields included
    set_config('1, '1, '1, '1, '1, '1, '1);
    send_random(80);
    drain();

    // overlapping bands; long run of checks saturates the stall counter
    set_config(14'd2000, 14'd2100, 14'd300, 14'd600, 14'd3400, 14'd40, 14'd255);
    repeat (270) begin
      send_req(REQ_CHECK, SAMPLE_W'($urandom));
      if ($urandom_range(0, 5) == 0) idle_req($urandom_range(1, 7));
    end
    send_random(60);
    drain();

    // random settings
    set_config(CFG_DATA_W'($urandom_range(0, 4092)), CFG_DATA_W'($urandom_range(0, 4092)),
               CFG_DATA_W'($urandom_range(0, 400)), CFG_DATA_W'($urandom_range(0, 4092)),
               CFG_DATA_W'($urandom_range(0, 4092)), CFG_DATA_W'($urandom_range(0, 64)),
               CFG_DATA_W'($urandom_range(0, 40)));
    send_random(150);
    drain();

    // close above open
    set_config(14'd3000, 14'd1000, 14'd100, 14'd3000, 14'd1000, 14'd0, 14'd1);
    send_random(80);
    drain();

    // back to reset values, no idling on either side
    idle_on = 1'b0;
    set_config(CLOSE_THR_RST, OPEN_THR_RST, CFG_DATA_W'(HYST_WIDTH_RST), MOTOR_CLOSE_THR_RST,
               MOTOR_OPEN_THR_RST, MOVE_DELTA_RST, CFG_DATA_W'(STALL_LIMIT_RST));
    send_random(100);
    drain();
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("tb_position_sum_hysteresis_classifier: clean");
    end else begin
      $display("tb_position_sum_hysteresis_classifier: errors");
    end
    $finish;
  end

endmodule
